FILE: rtl/fqsd_pkg.sv
package fqsd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int MODE_W     = 2;
    localparam int ID_W       = 16;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int ENTRY_W    = ID_W + HANDLE_W;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_MV_RD,
        ST_MV_WR,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/fqsd_ram.sv
module fqsd_ram #(
    parameter int DEPTH = fqsd_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(fqsd_pkg::QUEUE_DEPTH_DEF),
    parameter int DW    = fqsd_pkg::ENTRY_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fifo_queue_with_id_search_delete_top.sv
// channel | dir | handshake          | tdata fields (lowest bit first)
// s       | in  | s_tvalid, s_tready | mode[1:0], task_id[17:2], task_handle[33:18]
// m       | out | m_tvalid, m_tready | status[1:0], found_id[17:2], found_handle[33:18],
//         |     |                    | occupancy[38:34]
// Push, accepted or refused as full, and any command on an empty queue go straight to done.
// Find reads and compares entries from slot 0 in order up to a hit; a miss scans all n entries.
// Pop or delete at slot k then moves each later entry down one slot (n-k-1 moves).
// The entry RAM has one write port and one read port with a registered read; one compare per entry.
// s_tready is low while a command runs; a result waits in the output register.
// rst_n clears the entry count; entry storage is not cleared.
module fifo_queue_with_id_search_delete_top #(
    parameter int QUEUE_DEPTH = fqsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fqsd_pkg::S_TDATA_W-1:0] s_tdata,   // mode, task_id, task_handle
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fqsd_pkg::M_TDATA_W-1:0] m_tdata    // status, found_id, found_handle, occupancy
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W  = fqsd_pkg::ID_W;
    localparam int HW    = fqsd_pkg::HANDLE_W;
    localparam int EW    = fqsd_pkg::ENTRY_W;
    localparam int MW    = fqsd_pkg::MODE_W;
    localparam int SW    = fqsd_pkg::STATUS_W;

    fqsd_pkg::state_t state_reg, state_next;

    logic [MW-1:0]    mode_reg, mode_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SW-1:0]    res_status_reg, res_status_next;
    logic [ID_W-1:0]  res_id_reg, res_id_next;
    logic [HW-1:0]    res_hnd_reg, res_hnd_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [fqsd_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [MW-1:0]    in_mode;
    logic [ID_W-1:0]  in_id;
    logic [HW-1:0]    in_hnd;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] count_dec;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [EW-1:0]    ram_rdata;

    assign in_mode   = s_tdata[MW-1:0];
    assign in_id     = s_tdata[MW+ID_W-1:MW];
    assign in_hnd    = s_tdata[MW+ID_W+HW-1:MW+ID_W];
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    fqsd_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IDX_W),
        .DW    (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fqsd_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_hnd_reg    <= res_hnd_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_hnd_next    = res_hnd_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            fqsd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next       = in_mode;
                    key_next        = in_id;
                    idx_next        = '0;
                    res_status_next = fqsd_pkg::STATUS_OK;
                    res_id_next     = '0;
                    res_hnd_next    = '0;
                    state_next      = fqsd_pkg::ST_DONE;
                    if (in_mode == fqsd_pkg::MODE_PUSH)
                    begin
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = fqsd_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = {in_id, in_hnd};
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = fqsd_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = fqsd_pkg::ST_SCAN;
                    end
                end
            end
            fqsd_pkg::ST_SCAN:
            begin
                ram_raddr  = idx_reg;
                state_next = fqsd_pkg::ST_CMP;
            end
            fqsd_pkg::ST_CMP:
            begin
                if (mode_reg == fqsd_pkg::MODE_POP || ram_rdata[EW-1:HW] == key_reg)
                begin
                    res_id_next  = ram_rdata[EW-1:HW];
                    res_hnd_next = ram_rdata[HW-1:0];
                    if (mode_reg == fqsd_pkg::MODE_FIND)
                    begin
                        state_next = fqsd_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = fqsd_pkg::ST_MV_RD;
                    end
                end
                else if (idx_inc >= count_reg)
                begin
                    res_status_next = fqsd_pkg::STATUS_NOT_FOUND;
                    state_next      = fqsd_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = fqsd_pkg::ST_SCAN;
                end
            end
            fqsd_pkg::ST_MV_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    ram_raddr  = idx_inc[IDX_W-1:0];
                    state_next = fqsd_pkg::ST_MV_WR;
                end
                else
                begin
                    count_next = count_dec;
                    state_next = fqsd_pkg::ST_DONE;
                end
            end
            fqsd_pkg::ST_MV_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc[IDX_W-1:0];
                state_next = fqsd_pkg::ST_MV_RD;
            end
            fqsd_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, fqsd_pkg::OCC_W'(count_reg),
                                     res_hnd_reg, res_id_reg, res_status_reg};
                    state_next    = fqsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fqsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == fqsd_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_mode == fqsd_pkg::MODE_PUSH
         && count_reg < CNT_W'(QUEUE_DEPTH))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not add an entry");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fqsd_pkg::ST_DONE && m_tvalid_reg && !m_tready)
        |=> state_reg == fqsd_pkg::ST_DONE)
        else $error("result overwrote an untaken item");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[fqsd_pkg::STATUS_W-1:0] == fqsd_pkg::STATUS_EMPTY)
        |-> m_tdata[38:34] == '0)
        else $error("empty status with nonzero occupancy");
`endif

endmodule
